// ===== hdl/tbp_pkg.sv =====
package tbp_pkg;

  localparam int LOCAL_HIST_BITS  = 10;
  localparam int GLOBAL_HIST_BITS = 12;
  localparam int PC_INDEX_BITS    = 10;

  localparam int ADDR_BITS = 32;

  localparam int LCTR_BITS = 3;
  localparam int GCTR_BITS = 2;
  localparam int CH_BITS   = 2;

  localparam logic [LCTR_BITS-1:0] LCTR_MAX = LCTR_BITS'(7);
  localparam logic [GCTR_BITS-1:0] GCTR_MAX = GCTR_BITS'(3);
  localparam logic [CH_BITS-1:0]   CH_MAX   = CH_BITS'(3);

  localparam int PC_ENTRIES = 1 << PC_INDEX_BITS;
  localparam int LH_ENTRIES = 1 << LOCAL_HIST_BITS;
  localparam int GH_ENTRIES = 1 << GLOBAL_HIST_BITS;

  // Sweep length covers the deepest table
  localparam int CLR_BITS_A = (PC_INDEX_BITS > LOCAL_HIST_BITS) ? PC_INDEX_BITS
                                                                 : LOCAL_HIST_BITS;
  localparam int CLR_BITS   = (CLR_BITS_A > GLOBAL_HIST_BITS) ? CLR_BITS_A
                                                               : GLOBAL_HIST_BITS;

  localparam int FIFO_DEPTH    = 4;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic predict_taken;
    logic used_global;
  } result_t;

endpackage

// ===== hdl/tbp_if.sv =====
interface tbp_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [tbp_pkg::ADDR_BITS-1:0]  branch_addr;
  logic                           is_cond;
  logic                           outcome;

  modport source (output valid, mode, branch_addr, is_cond, outcome, input ready);
  modport sink   (input valid, mode, branch_addr, is_cond, outcome, output ready);
endinterface

interface tbp_out_if;
  logic valid;
  logic ready;
  logic predict_taken;
  logic used_global;

  modport source (output valid, predict_taken, used_global, input ready);
  modport sink   (input valid, predict_taken, used_global, output ready);
endinterface

// ===== hdl/tournament_branch_predictor_unit.sv =====
// Channel | Dir | Payload                                | Transfer
// req     | in  | mode, branch_addr, is_cond, outcome    | valid & ready
// rsp     | out | predict_taken, used_global             | valid & ready
//
// One branch per cycle while req.ready is high: table reads are issued at the req
// transfer, the local counter read is issued from stage 1, and stage 2 pushes the
// result into the output queue, from which rsp is served.
// After reset a clearing pass writes every table entry, one a cycle, over
// 2^max(index widths) = 4096 indices with req.ready low.
// req.ready drops whenever the output queue could not absorb the items in flight.
module tournament_branch_predictor_unit (
  input logic       clk,
  input logic       rst,
  tbp_in_if.sink    req,
  tbp_out_if.source rsp
);

  localparam int LH = tbp_pkg::LOCAL_HIST_BITS;
  localparam int GH = tbp_pkg::GLOBAL_HIST_BITS;
  localparam int PC = tbp_pkg::PC_INDEX_BITS;
  localparam int LC = tbp_pkg::LCTR_BITS;
  localparam int GC = tbp_pkg::GCTR_BITS;
  localparam int CH = tbp_pkg::CH_BITS;
  localparam int OCC_BITS = tbp_pkg::FIFO_CNT_BITS + 1;

  // clearing pass
  logic                        clearing;
  logic [tbp_pkg::CLR_BITS-1:0] clr_idx;

  // path history
  logic [GH-1:0] path_hist;

  // stage 1
  logic          s1_valid;
  logic          s1_mode;
  logic          s1_cond;
  logic          s1_taken;
  logic [PC-1:0] s1_pci;
  logic [GH-1:0] s1_gh;

  // stage 2
  logic          s2_valid;
  logic          s2_mode;
  logic          s2_cond;
  logic          s2_taken;
  logic [LH-1:0] s2_lh;
  logic [GH-1:0] s2_gh;
  logic [GC-1:0] s2_gc;
  logic [CH-1:0] s2_ch;

  // last writes, for reads that were issued before them
  logic          lw_en;
  logic [PC-1:0] lw_addr;
  logic [LH-1:0] lw_data;
  logic          cw_en;
  logic [LH-1:0] cw_addr;
  logic [LC-1:0] cw_data;
  logic          gw_en;
  logic [GH-1:0] gw_addr;
  logic [GC-1:0] gw_gc;
  logic [CH-1:0] gw_ch;

  // ram ports
  logic          lht_we;
  logic [PC-1:0] lht_waddr;
  logic [LH-1:0] lht_wdata;
  logic [LH-1:0] lht_rdata;
  logic          lc_we;
  logic [LH-1:0] lc_waddr;
  logic [LC-1:0] lc_wdata;
  logic [LC-1:0] lc_rdata;
  logic          g_we;
  logic [GH-1:0] g_waddr;
  logic [GC-1:0] gc_wdata;
  logic [CH-1:0] ch_wdata;
  logic [GC-1:0] gc_rdata;
  logic [CH-1:0] ch_rdata;

  // item logic
  logic          acc;
  logic          lht_upd;
  logic [LH-1:0] lh1;
  logic [LH-1:0] lh1_next;
  logic [GC-1:0] gc1;
  logic [CH-1:0] ch1;
  logic [GC-1:0] gc2;
  logic [CH-1:0] ch2;
  logic [LC-1:0] lc2;
  logic          lpred;
  logic          gpred;
  logic          useg;
  logic          ctr_upd;
  logic [GC-1:0] gc_next;
  logic [CH-1:0] ch_next;
  logic [LC-1:0] lc_next;

  tbp_pkg::result_t                  res;
  tbp_pkg::result_t                  out_data;
  logic [tbp_pkg::FIFO_CNT_BITS-1:0] q_count;
  logic [OCC_BITS-1:0]               occ;

  assign acc = req.valid & req.ready;
  assign occ = OCC_BITS'(q_count) + OCC_BITS'(s1_valid) + OCC_BITS'(s2_valid);
  assign req.ready = !clearing && (occ < OCC_BITS'(tbp_pkg::FIFO_DEPTH));

  // ---- stage 1: local history and global counters with bypass, start local counter read
  always_comb begin
    lh1 = (lw_en && lw_addr == s1_pci) ? lw_data : lht_rdata;
    gc1 = (gw_en && gw_addr == s1_gh) ? gw_gc : gc_rdata;
    ch1 = (gw_en && gw_addr == s1_gh) ? gw_ch : ch_rdata;
    lh1_next = {lh1[LH-2:0], s1_taken};
    lht_upd  = s1_valid && s1_mode;
  end

  // ---- stage 2: predict and train
  always_comb begin
    gc2 = (gw_en && gw_addr == s2_gh) ? gw_gc : s2_gc;
    ch2 = (gw_en && gw_addr == s2_gh) ? gw_ch : s2_ch;
    lc2 = (cw_en && cw_addr == s2_lh) ? cw_data : lc_rdata;

    lpred = lc2[LC-1];
    gpred = gc2[GC-1];
    useg  = ch2[CH-1];

    if (s2_cond) begin
      res.predict_taken = useg ? gpred : lpred;
      res.used_global   = useg;
    end else begin
      res.predict_taken = 1'b1;
      res.used_global   = 1'b0;
    end

    ctr_upd = s2_valid && s2_mode && s2_cond;

    ch_next = ch2;
    if (gpred == s2_taken && lpred != s2_taken && ch2 != tbp_pkg::CH_MAX) begin
      ch_next = ch2 + CH'(1);
    end else if (gpred != s2_taken && lpred == s2_taken && ch2 != '0) begin
      ch_next = ch2 - CH'(1);
    end

    if (s2_taken) begin
      gc_next = (gc2 == tbp_pkg::GCTR_MAX) ? gc2 : gc2 + GC'(1);
      lc_next = (lc2 == tbp_pkg::LCTR_MAX) ? lc2 : lc2 + LC'(1);
    end else begin
      gc_next = (gc2 == '0) ? gc2 : gc2 - GC'(1);
      lc_next = (lc2 == '0) ? lc2 : lc2 - LC'(1);
    end
  end

  // ---- ram write ports, taken over by the clearing pass after reset
  always_comb begin
    if (clearing) begin
      lht_we    = 1'b1;
      lht_waddr = clr_idx[PC-1:0];
      lht_wdata = '0;
      lc_we     = 1'b1;
      lc_waddr  = clr_idx[LH-1:0];
      lc_wdata  = '0;
      g_we      = 1'b1;
      g_waddr   = clr_idx[GH-1:0];
      gc_wdata  = '0;
      ch_wdata  = '0;
    end else begin
      lht_we    = lht_upd;
      lht_waddr = s1_pci;
      lht_wdata = lh1_next;
      lc_we     = ctr_upd;
      lc_waddr  = s2_lh;
      lc_wdata  = lc_next;
      g_we      = ctr_upd;
      g_waddr   = s2_gh;
      gc_wdata  = gc_next;
      ch_wdata  = ch_next;
    end
  end

  // ---- control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing  <= 1'b1;
      clr_idx   <= '0;
      path_hist <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      lw_en     <= 1'b0;
      cw_en     <= 1'b0;
      gw_en     <= 1'b0;
    end else begin
      if (clearing) begin
        clr_idx <= clr_idx + tbp_pkg::CLR_BITS'(1);
        if (clr_idx == '1) begin
          clearing <= 1'b0;
        end
      end
      // path history depends on the outcome alone, so advance it at the transfer
      if (acc && req.mode && req.is_cond) begin
        path_hist <= {path_hist[GH-2:0], req.outcome};
      end
      s1_valid <= acc;
      s2_valid <= s1_valid;
      lw_en    <= lht_upd;
      cw_en    <= ctr_upd;
      gw_en    <= ctr_upd;
    end
  end

  // ---- payload registers
  always_ff @(posedge clk) begin
    s1_mode  <= req.mode;
    s1_cond  <= req.is_cond;
    s1_taken <= req.outcome;
    s1_pci   <= req.branch_addr[PC+1:2];
    s1_gh    <= path_hist;

    s2_mode  <= s1_mode;
    s2_cond  <= s1_cond;
    s2_taken <= s1_taken;
    s2_lh    <= lh1;
    s2_gh    <= s1_gh;
    s2_gc    <= gc1;
    s2_ch    <= ch1;

    lw_addr  <= s1_pci;
    lw_data  <= lh1_next;
    cw_addr  <= s2_lh;
    cw_data  <= lc_next;
    gw_addr  <= s2_gh;
    gw_gc    <= gc_next;
    gw_ch    <= ch_next;
  end

  tbp_ram #(.WIDTH(LH), .DEPTH(tbp_pkg::PC_ENTRIES)) u_lht (
    .clk   (clk),
    .we    (lht_we),
    .waddr (lht_waddr),
    .wdata (lht_wdata),
    .raddr (req.branch_addr[PC+1:2]),
    .rdata (lht_rdata)
  );

  tbp_ram #(.WIDTH(LC), .DEPTH(tbp_pkg::LH_ENTRIES)) u_lctr (
    .clk   (clk),
    .we    (lc_we),
    .waddr (lc_waddr),
    .wdata (lc_wdata),
    .raddr (lh1),
    .rdata (lc_rdata)
  );

  tbp_ram #(.WIDTH(GC), .DEPTH(tbp_pkg::GH_ENTRIES)) u_gctr (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (gc_wdata),
    .raddr (path_hist),
    .rdata (gc_rdata)
  );

  tbp_ram #(.WIDTH(CH), .DEPTH(tbp_pkg::GH_ENTRIES)) u_chooser (
    .clk   (clk),
    .we    (g_we),
    .waddr (g_waddr),
    .wdata (ch_wdata),
    .raddr (path_hist),
    .rdata (ch_rdata)
  );

  tbp_fifo u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (s2_valid),
    .push_data (res),
    .pop       (rsp.valid & rsp.ready),
    .pop_data  (out_data),
    .count     (q_count)
  );

  assign rsp.valid         = (q_count != '0);
  assign rsp.predict_taken = out_data.predict_taken;
  assign rsp.used_global   = out_data.used_global;

endmodule

// ===== hdl/tbp_ram.sv =====
module tbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/tbp_fifo.sv =====
module tbp_fifo (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 push,
  input  tbp_pkg::result_t                     push_data,
  input  logic                                 pop,
  output tbp_pkg::result_t                     pop_data,
  output logic [tbp_pkg::FIFO_CNT_BITS-1:0]    count
);

  tbp_pkg::result_t                   buf_q [tbp_pkg::FIFO_DEPTH];
  logic [tbp_pkg::FIFO_PTR_BITS-1:0]  wr_ptr;
  logic [tbp_pkg::FIFO_PTR_BITS-1:0]  rd_ptr;

  assign pop_data = buf_q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      buf_q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + tbp_pkg::FIFO_PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + tbp_pkg::FIFO_PTR_BITS'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + tbp_pkg::FIFO_CNT_BITS'(1);
        2'b01:   count <= count - tbp_pkg::FIFO_CNT_BITS'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sim/tbp_tb_pkg.sv =====
package tbp_tb_pkg;

  typedef enum logic {
    MODE_PREDICT = 1'b0,
    MODE_TRAIN   = 1'b1
  } branch_mode_e;

endpackage

// ===== sim/branch_check.sv =====
module branch_check (
  input  logic clk,
  input  logic rst,
  tbp_in_if    req,
  tbp_out_if   rsp,
  output int   fail_count,
  output int   awaited
);
  timeunit 1ns;
  timeprecision 1ps;

  import tbp_pkg::*;
  import tbp_tb_pkg::*;

  logic [LOCAL_HIST_BITS-1:0]  hist_of_pc [PC_ENTRIES];
  logic [LCTR_BITS-1:0]        local_ctr  [LH_ENTRIES];
  logic [GCTR_BITS-1:0]        global_ctr [GH_ENTRIES];
  logic [CH_BITS-1:0]          chooser    [GH_ENTRIES];
  logic [GLOBAL_HIST_BITS-1:0] path;

  result_t direction_q [$];

  task automatic report_mismatch(input string msg);
    $display("%0t ns  %s", $time, msg);
    fail_count++;
  endtask

  // Work out the direction from the current tables, then train them if asked
  task automatic resolve_branch(input logic mode, input logic [ADDR_BITS-1:0] addr,
                                input logic cond, input logic taken,
                                output result_t dir);
    logic [PC_INDEX_BITS-1:0]    pci;
    logic [LOCAL_HIST_BITS-1:0]  lh;
    logic [GLOBAL_HIST_BITS-1:0] gh;
    logic [LCTR_BITS-1:0]        lc;
    logic [GCTR_BITS-1:0]        gc;
    logic [CH_BITS-1:0]          ch;
    logic                        local_says, global_says, pick_global;
    pci = addr[PC_INDEX_BITS+1:2];
    lh  = hist_of_pc[pci];
    gh  = path;
    lc  = local_ctr[lh];
    gc  = global_ctr[gh];
    ch  = chooser[gh];
    // each counter predicts taken in the upper half of its range
    local_says  = lc[LCTR_BITS-1];
    global_says = gc[GCTR_BITS-1];
    pick_global = ch[CH_BITS-1];
    dir.predict_taken = cond ? (pick_global ? global_says : local_says) : 1'b1;
    dir.used_global   = cond & pick_global;
    if (mode == MODE_TRAIN) begin
      if (cond) begin
        if (global_says == taken && local_says != taken && ch != CH_MAX) begin
          chooser[gh] = ch + 1'b1;
        end else if (global_says != taken && local_says == taken && ch != '0) begin
          chooser[gh] = ch - 1'b1;
        end
        if (taken) begin
          if (gc != GCTR_MAX) global_ctr[gh] = gc + 1'b1;
          if (lc != LCTR_MAX) local_ctr[lh] = lc + 1'b1;
        end else begin
          if (gc != '0) global_ctr[gh] = gc - 1'b1;
          if (lc != '0) local_ctr[lh] = lc - 1'b1;
        end
        path = {gh[GLOBAL_HIST_BITS-2:0], taken};
      end
      hist_of_pc[pci] = {lh[LOCAL_HIST_BITS-2:0], taken};
    end
  endtask

  always @(posedge clk) begin
    result_t want, got;
    if (rst) begin
      foreach (hist_of_pc[i]) hist_of_pc[i] = '0;
      foreach (local_ctr[i]) local_ctr[i] = '0;
      foreach (global_ctr[i]) global_ctr[i] = '0;
      foreach (chooser[i]) chooser[i] = '0;
      path = '0;
      direction_q.delete();
      fail_count = 0;
    end else begin
      // retire the oldest expectation before queueing this edge's request
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        if (direction_q.size() == 0) begin
          report_mismatch("response transfer with no prediction awaited");
        end else begin
          want = direction_q.pop_front();
          if (rsp.predict_taken !== want.predict_taken) begin
            report_mismatch($sformatf("predict_taken %b, expected %b",
                                      rsp.predict_taken, want.predict_taken));
          end
          if (rsp.used_global !== want.used_global) begin
            report_mismatch($sformatf("used_global %b, expected %b",
                                      rsp.used_global, want.used_global));
          end
        end
      end
      if (req.valid === 1'b1 && req.ready === 1'b1) begin
        resolve_branch(req.mode, req.branch_addr, req.is_cond, req.outcome, got);
        direction_q.push_back(got);
      end
    end
    awaited = direction_q.size();
  end

endmodule

// ===== sim/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tbp_pkg::*;
  import tbp_tb_pkg::*;

  localparam int CLOCK_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 900;
  localparam int CALM_ITEMS   = 120;
  localparam int PHASE_ITEMS  = 150;
  localparam int POOL         = 16;

  // how a pooled branch resolves when trained
  typedef enum int {
    K_TAKEN, K_NOT_TAKEN, K_TOGGLE, K_ECHO, K_COIN, K_JUMP
  } branch_kind_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   failures;
  int   in_flight;
  int   cycles;
  int   send_gap_pct   = 10;
  int   recv_stall_pct = 10;

  always #5 clk = ~clk;

  tbp_in_if  req ();
  tbp_out_if rsp ();

  tournament_branch_predictor_unit dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  branch_check u_check (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .fail_count (failures),
    .awaited    (in_flight)
  );

  task automatic issue(input branch_mode_e m, input logic [ADDR_BITS-1:0] a,
                       input logic c, input logic o);
    if (send_gap_pct > 0 && $urandom_range(1, 100) <= send_gap_pct) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.mode        <= m;
    req.branch_addr <= a;
    req.is_cond     <= c;
    req.outcome     <= o;
    do @(posedge clk); while (req.ready !== 1'b1);
  endtask

  initial begin
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (recv_stall_pct > 0 && $urandom_range(1, 100) <= recv_stall_pct) begin
        rsp.ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      rsp.ready <= 1'b1;
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CLOCK_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [PC_INDEX_BITS-1:0] pool_idx  [POOL];
    branch_kind_e             pool_kind [POOL];
    logic                     pool_phase[POOL];
    logic                     last_dir;
    logic [ADDR_BITS-1:0]     a;
    branch_mode_e             m;
    logic                     c, o;
    int                       e, pick;
    req.valid       <= 1'b0;
    req.mode        <= MODE_PREDICT;
    req.branch_addr <= '0;
    req.is_cond     <= 1'b0;
    req.outcome     <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // fresh tables, unconditional handling, address extremes, ignored outcome
    issue(MODE_PREDICT, 32'h0000_0000, 1'b1, 1'b1);
    issue(MODE_PREDICT, 32'hFFFF_FFFF, 1'b0, 1'b0);
    issue(MODE_TRAIN,   32'hFFFF_FFFF, 1'b0, 1'b1);
    issue(MODE_TRAIN,   32'hFFFF_FFFF, 1'b0, 1'b0);
    issue(MODE_PREDICT, 32'hFFFF_FFFF, 1'b1, 1'b1);
    issue(MODE_TRAIN,   32'hAAAA_AAAA, 1'b1, 1'b1);
    issue(MODE_TRAIN,   32'h5555_5555, 1'b1, 1'b0);
    // hammer one branch taken so its counters climb
    repeat (12) issue(MODE_TRAIN, 32'h0000_0FFC, 1'b1, 1'b1);
    issue(MODE_PREDICT, 32'h0000_0FFC, 1'b1, 1'b0);
    issue(MODE_TRAIN,   32'hFFFF_F000, 1'b1, 1'b0);
    issue(MODE_PREDICT, 32'hFFFF_F000, 1'b1, 1'b1);

    foreach (pool_idx[i]) begin
      pool_idx[i]   = PC_INDEX_BITS'($urandom);
      pool_kind[i]  = branch_kind_e'(i % 6);
      pool_phase[i] = 1'b0;
    end
    last_dir = 1'b0;

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n >= RANDOM_ITEMS - CALM_ITEMS) begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end else if (n % PHASE_ITEMS == 0) begin
        pick = $urandom_range(0, 3);
        send_gap_pct = (pick == 0) ? 0 : (pick == 1) ? 5 : (pick == 2) ? 15 : 30;
        pick = $urandom_range(0, 3);
        recv_stall_pct = (pick == 0) ? 0 : (pick == 1) ? 5 : (pick == 2) ? 15 : 30;
      end

      a = $urandom;
      if ($urandom_range(0, 99) < 10) begin
        // noise: anything at all
        m = branch_mode_e'($urandom_range(0, 1));
        c = 1'($urandom);
        o = 1'($urandom);
        if (m == MODE_TRAIN && c) last_dir = o;
      end else begin
        e = $urandom_range(0, POOL - 1);
        a[PC_INDEX_BITS+1:2] = pool_idx[e];
        m = ($urandom_range(0, 99) < 80) ? MODE_TRAIN : MODE_PREDICT;
        c = (pool_kind[e] != K_JUMP);
        case (pool_kind[e])
          K_TAKEN:     o = 1'b1;
          K_NOT_TAKEN: o = 1'b0;
          K_TOGGLE:    o = pool_phase[e];
          K_ECHO:      o = last_dir;
          default:     o = 1'($urandom);
        endcase
        if (m == MODE_TRAIN) begin
          pool_phase[e] = ~pool_phase[e];
          if (c) last_dir = o;
        end else begin
          o = 1'($urandom);
        end
      end
      issue(m, a, c, o);
    end
    req.valid <= 1'b0;

    do @(posedge clk); while (in_flight != 0);
    repeat (10) @(posedge clk);
    if (failures == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tbp_pkg.sv
hdl/tbp_if.sv
hdl/tbp_ram.sv
hdl/tbp_fifo.sv
hdl/tournament_branch_predictor_unit.sv
sim/tbp_tb_pkg.sv
sim/branch_check.sv
sim/tb.sv
